### sv/hid_idle_report_scheduler_unit_macros.svh
// Assertion macros shared by the idle report scheduler RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef HID_IDLE_REPORT_SCHEDULER_UNIT_MACROS_SVH
`define HID_IDLE_REPORT_SCHEDULER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HIRS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define HIRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/hirs_pkg.sv
// Shared types and constants of the HID idle report scheduler.
// No dependencies; imported by the front, back and top modules of the block.
`default_nettype none
package hirs_pkg;

  localparam int HIRS_MAX_IDS = 8;
  localparam int MASK_W       = 8;

  localparam logic [1:0] FUNC_SET_IDLE = 2'd0;
  localparam logic [1:0] FUNC_GET_IDLE = 2'd1;
  localparam logic [1:0] FUNC_LOOP     = 2'd2;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [3:0] ACTIVE_IDS_RESET = 4'd4;
  localparam logic [7:0] IDLE_STEP        = 8'd5;
  localparam logic [7:0] IDLE_EXPIRE      = 8'd4;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] report_id;
    logic [7:0] rate;
    logic       frame_tick;
    logic [7:0] changed_mask;
    logic       idle_tick;
    logic       ep_ready;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] out_report_id;
    logic [7:0] rate_value;
    logic       ok;
    logic       last;
  } out_item_t;

  // work handed from front to back: one reply, or a mask of due reports
  typedef struct packed {
    logic              is_reply;
    logic [3:0]        rid;
    logic [7:0]        rv;
    logic              ok;
    logic [MASK_W-1:0] mask;
  } job_t;

endpackage
`default_nettype wire

### sv/hirs_fifo.sv
// Small register queue between the front and back parts.
// Depends on nothing but its parameters.
`default_nettype none
module hirs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PTR_W+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### sv/hirs_front.sv
// Front part: takes requests and loop passes, holds idle rates and counters,
// and queues replies or due-report masks. Depends on hirs_pkg.
`default_nettype none
module hirs_front #(
  parameter int MAX_IDS = hirs_pkg::HIRS_MAX_IDS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hirs_pkg::in_item_t item,
  output logic             full,
  input  logic             cfg_we,
  input  logic [3:0]       cfg_data,
  output logic             job_push,
  output hirs_pkg::job_t   job,
  input  logic             job_full
);
  import hirs_pkg::*;

  logic [7:0]         idle_rate  [MAX_IDS];
  logic [7:0]         idle_count [MAX_IDS];
  logic [7:0]         count_next [MAX_IDS];
  logic [3:0]         active_ids;
  logic [MASK_W-1:0]  due;
  logic [7:0]         get_rate;
  logic               accept;
  logic               in_range;
  logic               is_set;
  logic               is_get;
  logic               is_loop;

  assign full    = job_full;
  assign accept  = push && !job_full;
  assign is_set  = (item.func == FUNC_SET_IDLE);
  assign is_get  = (item.func == FUNC_GET_IDLE);
  assign is_loop = (item.func == FUNC_LOOP);
  assign in_range = (item.report_id != 8'd0) && (item.report_id <= 8'(MAX_IDS));

  always_comb begin
    due      = '0;
    get_rate = '0;
    for (int i = 0; i < MAX_IDS; i++) begin
      count_next[i] = idle_count[i];
      if (item.report_id == 8'(i + 1)) begin
        get_rate = idle_rate[i];
      end
      if (4'(i) < active_ids) begin
        if (item.frame_tick && item.changed_mask[i]) begin
          due[i] = 1'b1;
        end
        if (item.idle_tick && (idle_rate[i] != 8'd0)) begin
          if (idle_count[i] > IDLE_EXPIRE) begin
            count_next[i] = idle_count[i] - IDLE_STEP;
          end else begin
            count_next[i] = idle_rate[i];
            due[i]        = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    job_push     = accept && (is_get || (is_loop && item.ep_ready && (due != '0)));
    job.is_reply = is_get;
    job.rid      = in_range ? item.report_id[3:0] : 4'd0;
    job.rv       = in_range ? get_rate : 8'd0;
    job.ok       = in_range;
    job.mask     = due;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_ids <= ACTIVE_IDS_RESET;
      for (int i = 0; i < MAX_IDS; i++) begin
        idle_rate[i]  <= '0;
        idle_count[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        active_ids <= cfg_data;
      end
      for (int i = 0; i < MAX_IDS; i++) begin
        if (accept && is_set &&
            ((item.report_id == 8'd0) || (item.report_id == 8'(i + 1)))) begin
          idle_rate[i] <= item.rate;
        end
        if (accept && is_loop) begin
          idle_count[i] <= count_next[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

### sv/hirs_back.sv
// Back part: pops queued work and emits results through an output register,
// one per cycle unless stalled. Depends on hirs_pkg and the assertion macros.
`default_nettype none
`include "hid_idle_report_scheduler_unit_macros.svh"
module hirs_back (
  input  logic              clk,
  input  logic              rst,
  input  hirs_pkg::job_t    job,
  input  logic              job_empty,
  output logic              job_pop,
  output hirs_pkg::out_item_t result,
  output logic              empty,
  input  logic              pop
);
  import hirs_pkg::*;

  logic              busy;
  logic              is_reply;
  logic [3:0]        rid;
  logic [7:0]        rv;
  logic              ok;
  logic [MASK_W-1:0] mask;
  logic              out_valid;
  out_item_t         nxt;
  logic [MASK_W-1:0] low_bit;
  logic [3:0]        low_id;
  logic              load;

  assign empty   = !out_valid;
  assign job_pop = !busy && !job_empty;
  assign load    = busy && (!out_valid || pop);
  assign low_bit = mask & (~mask + 1'b1);

  always_comb begin
    low_id = 4'd0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (mask[i]) begin
        low_id = 4'(i + 1);
      end
    end
  end

  always_comb begin
    if (is_reply) begin
      nxt.kind          = KIND_REPLY;
      nxt.out_report_id = rid;
      nxt.rate_value    = rv;
      nxt.ok            = ok;
      nxt.last          = 1'b1;
    end else begin
      nxt.kind          = KIND_REPORT;
      nxt.out_report_id = low_id;
      nxt.rate_value    = 8'd0;
      nxt.ok            = 1'b1;
      nxt.last          = ((mask & ~low_bit) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= nxt;
    end
    if (job_pop) begin
      is_reply <= job.is_reply;
      rid      <= job.rid;
      rv       <= job.rv;
      ok       <= job.ok;
      mask     <= job.mask;
    end else if (load) begin
      mask <= mask & ~low_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        busy <= 1'b1;
      end else if (load && nxt.last) begin
        busy <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  `HIRS_ASSERT_SAME(a_due_job_nonempty, clk, rst, busy && !is_reply, mask != '0,
    "due job active with empty mask")
  `HIRS_ASSERT_NEXT(a_last_frees_back, clk, rst, load && nxt.last, !busy,
    "back still busy after last transfer")
  `HIRS_ASSERT_SAME(a_no_pop_while_busy, clk, rst, job_pop, !busy && !job_empty,
    "queue popped while a job is active")
  `HIRS_ASSERT_SAME(a_report_fields, clk, rst, out_valid && (result.kind == KIND_REPORT),
    result.ok && (result.rate_value == 8'd0) && (result.out_report_id != 4'd0),
    "due report transfer with bad fields")

endmodule
`default_nettype wire

### sv/hid_idle_report_scheduler_unit.sv
// HID idle report scheduler, top level.
// Input side is a queue: an item transfers when push is high and full is low.
// Result side is a queue: the oldest result sits on result while empty is
// low and transfers when pop is high. cfg_we/cfg_data write the active ID count.
// A set idle request updates the rate table at its transfer and yields no
// result. A get idle request yields one reply; a loop pass updates the idle
// counters at its transfer; if ep_ready, it reports each due ID, ascending.
// The first result of an item passes the job queue, the job registers and the
// output register; results then come one per cycle while pop stays high, 1 to 8
// per item; the back part takes a new job only once the last result is loaded.
// A two-entry job queue parts front and back, so the front keeps taking items
// while results wait; when the receiver stalls, the output register holds,
// the queue fills and full rises.
// Reset clears all rates and counters, sets the active ID count to 4 and
// empties the queue and output register. Depends on hirs_pkg, hirs_front,
// hirs_fifo and hirs_back.
`default_nettype none
module hid_idle_report_scheduler_unit #(
  parameter int MAX_IDS = hirs_pkg::HIRS_MAX_IDS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hirs_pkg::in_item_t  item,
  output logic                full,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data,
  output hirs_pkg::out_item_t result,
  output logic                empty,
  input  logic                pop
);
  import hirs_pkg::*;

  logic job_push;
  logic job_full;
  logic job_pop;
  logic job_empty;
  job_t job_in;
  job_t job_out;

  hirs_front #(
    .MAX_IDS (MAX_IDS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .job_push (job_push),
    .job      (job_in),
    .job_full (job_full)
  );

  hirs_fifo #(
    .W     ($bits(job_t)),
    .DEPTH (2)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  hirs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire
